### sv/ghsm_pkg.sv
// Shared field widths, action and status codes for the generational slot map.
package ghsm_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int GEN_WIDTH_DEF = 16;

    localparam int ACTION_W    = 2;
    localparam int IN_SLOT_W   = 8;
    localparam int IN_GEN_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int OUT_SLOT_W  = 6;
    localparam int OUT_GEN_W   = 16;
    localparam int OUT_IDX_W   = 6;
    localparam int OUT_COUNT_W = 7;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

### sv/ghsm_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module ghsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/ghsm_ctrl.sv
// Sequencer: handle checks, dense packing and free list over the slot and index memories.
module ghsm_ctrl import ghsm_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int GEN_WIDTH = GEN_WIDTH_DEF,
    parameter int SW        = $clog2(CAPACITY),
    parameter int A_W       = 1 + GEN_WIDTH + SW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ACTION_W-1:0]    action,
    input  logic [IN_SLOT_W-1:0]   slot,
    input  logic [IN_GEN_W-1:0]    generation,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [OUT_SLOT_W-1:0]  out_slot,
    output logic [OUT_GEN_W-1:0]   out_generation,
    output logic [OUT_IDX_W-1:0]   dense_index,
    output logic                   moved,
    output logic [OUT_IDX_W-1:0]   moved_from,
    output logic [OUT_COUNT_W-1:0] live_count,
    output logic                   a_we,
    output logic [SW-1:0]          a_waddr,
    output logic [A_W-1:0]         a_wdata,
    output logic                   a_re,
    output logic [SW-1:0]          a_raddr,
    input  logic [A_W-1:0]         a_rdata,
    output logic                   b_we,
    output logic [SW-1:0]          b_waddr,
    output logic [SW-1:0]          b_wdata,
    output logic                   b_re,
    output logic [SW-1:0]          b_raddr,
    input  logic [SW-1:0]          b_rdata
);

    localparam int LW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_ADD,
        S_MOVE,
        S_FIX
    } state_t;

    state_t                 state_reg, state_next;
    logic [SW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0]          live_reg, live_next;
    logic [ACTION_W-1:0]    act_reg, act_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic                   slot_ok_reg, slot_ok_next;
    logic [GEN_WIDTH-1:0]   gen_reg, gen_next;
    logic [SW-1:0]          d_reg, d_next;
    logic [SW-1:0]          ms_reg, ms_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [OUT_SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [OUT_GEN_W-1:0]   out_gen_reg, out_gen_next;
    logic [OUT_IDX_W-1:0]   dense_reg, dense_next;
    logic                   moved_reg, moved_next;
    logic [OUT_IDX_W-1:0]   moved_from_reg, moved_from_next;
    logic [OUT_COUNT_W-1:0] count_reg, count_next;

    logic                   a_live;
    logic [GEN_WIDTH-1:0]   a_gen;
    logic [SW-1:0]          a_s2d;
    logic [SW-1:0]          last_idx;
    logic                   out_free;
    logic                   handle_ok;

    assign a_live    = a_rdata[A_W-1];
    assign a_gen     = a_rdata[SW +: GEN_WIDTH];
    assign a_s2d     = a_rdata[SW-1:0];
    assign last_idx  = SW'(live_reg - LW'(1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign handle_ok = slot_ok_reg && a_live && (a_gen == gen_reg);
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        live_next       = live_reg;
        act_next        = act_reg;
        slot_next       = slot_reg;
        slot_ok_next    = slot_ok_reg;
        gen_next        = gen_reg;
        d_next          = d_reg;
        ms_next         = ms_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        out_slot_next   = out_slot_reg;
        out_gen_next    = out_gen_reg;
        dense_next      = dense_reg;
        moved_next      = moved_reg;
        moved_from_next = moved_from_reg;
        count_next      = count_reg;

        a_we    = 1'b0;
        a_waddr = slot_reg;
        a_wdata = '0;
        a_re    = 1'b0;
        a_raddr = slot_reg;
        b_we    = 1'b0;
        b_waddr = last_idx;
        b_wdata = slot_reg;
        b_re    = 1'b0;
        b_raddr = last_idx;

        case (state_reg)
            S_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_cnt_reg;
                a_wdata = '0;
                b_we    = 1'b1;
                b_waddr = clr_cnt_reg;
                b_wdata = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SW'(1);
                if (clr_cnt_reg == SW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = action;
                    slot_next    = SW'(slot);
                    slot_ok_next = (32'(slot) < 32'(CAPACITY));
                    gen_next     = GEN_WIDTH'(generation);
                    a_re         = 1'b1;
                    a_raddr      = SW'(slot);
                    b_re         = 1'b1;
                    b_raddr      = SW'(live_reg);
                    state_next   = S_LOOK;
                end
            end

            S_LOOK:
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (live_reg == LW'(CAPACITY))
                        begin
                            if (out_free)
                            begin
                                out_valid_next  = 1'b1;
                                status_next     = ST_FULL;
                                out_slot_next   = '0;
                                out_gen_next    = '0;
                                dense_next      = '0;
                                moved_next      = 1'b0;
                                moved_from_next = '0;
                                count_next      = OUT_COUNT_W'(live_reg);
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            ms_next    = b_rdata;
                            a_re       = 1'b1;
                            a_raddr    = b_rdata;
                            state_next = S_ADD;
                        end
                    end

                    ACT_UPDATE:
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            status_next     = handle_ok ? ST_OK : ST_BAD;
                            out_slot_next   = handle_ok ? OUT_SLOT_W'(slot_reg) : '0;
                            out_gen_next    = '0;
                            dense_next      = handle_ok ? OUT_IDX_W'(a_s2d) : '0;
                            moved_next      = 1'b0;
                            moved_from_next = '0;
                            count_next      = OUT_COUNT_W'(live_reg);
                            state_next      = S_IDLE;
                        end
                    end

                    ACT_REMOVE:
                    begin
                        if (!handle_ok)
                        begin
                            if (out_free)
                            begin
                                out_valid_next  = 1'b1;
                                status_next     = ST_BAD;
                                out_slot_next   = '0;
                                out_gen_next    = '0;
                                dense_next      = '0;
                                moved_next      = 1'b0;
                                moved_from_next = '0;
                                count_next      = OUT_COUNT_W'(live_reg);
                                state_next      = S_IDLE;
                            end
                        end
                        else if (a_s2d == last_idx)
                        begin
                            if (out_free)
                            begin
                                a_we            = 1'b1;
                                a_waddr         = slot_reg;
                                a_wdata         = {1'b0, a_gen + GEN_WIDTH'(1), a_s2d};
                                b_we            = 1'b1;
                                b_waddr         = last_idx;
                                b_wdata         = slot_reg;
                                live_next       = live_reg - LW'(1);
                                out_valid_next  = 1'b1;
                                status_next     = ST_OK;
                                out_slot_next   = OUT_SLOT_W'(slot_reg);
                                out_gen_next    = '0;
                                dense_next      = OUT_IDX_W'(a_s2d);
                                moved_next      = 1'b0;
                                moved_from_next = '0;
                                count_next      = OUT_COUNT_W'(live_reg - LW'(1));
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            a_we       = 1'b1;
                            a_waddr    = slot_reg;
                            a_wdata    = {1'b0, a_gen + GEN_WIDTH'(1), a_s2d};
                            d_next     = a_s2d;
                            b_re       = 1'b1;
                            b_raddr    = last_idx;
                            state_next = S_MOVE;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            status_next     = ST_BAD;
                            out_slot_next   = '0;
                            out_gen_next    = '0;
                            dense_next      = '0;
                            moved_next      = 1'b0;
                            moved_from_next = '0;
                            count_next      = OUT_COUNT_W'(live_reg);
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end

            S_ADD:
            begin
                if (out_free)
                begin
                    a_we            = 1'b1;
                    a_waddr         = ms_reg;
                    a_wdata         = {1'b1, a_gen, SW'(live_reg)};
                    live_next       = live_reg + LW'(1);
                    out_valid_next  = 1'b1;
                    status_next     = ST_OK;
                    out_slot_next   = OUT_SLOT_W'(ms_reg);
                    out_gen_next    = OUT_GEN_W'(a_gen);
                    dense_next      = OUT_IDX_W'(live_reg);
                    moved_next      = 1'b0;
                    moved_from_next = '0;
                    count_next      = OUT_COUNT_W'(live_reg + LW'(1));
                    state_next      = S_IDLE;
                end
            end

            S_MOVE:
            begin
                b_we       = 1'b1;
                b_waddr    = d_reg;
                b_wdata    = b_rdata;
                ms_next    = b_rdata;
                a_re       = 1'b1;
                a_raddr    = b_rdata;
                state_next = S_FIX;
            end

            S_FIX:
            begin
                if (out_free)
                begin
                    a_we            = 1'b1;
                    a_waddr         = ms_reg;
                    a_wdata         = {a_live, a_gen, d_reg};
                    b_we            = 1'b1;
                    b_waddr         = last_idx;
                    b_wdata         = slot_reg;
                    live_next       = live_reg - LW'(1);
                    out_valid_next  = 1'b1;
                    status_next     = ST_OK;
                    out_slot_next   = OUT_SLOT_W'(slot_reg);
                    out_gen_next    = '0;
                    dense_next      = OUT_IDX_W'(d_reg);
                    moved_next      = 1'b1;
                    moved_from_next = OUT_IDX_W'(last_idx);
                    count_next      = OUT_COUNT_W'(live_reg - LW'(1));
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            live_reg       <= '0;
            act_reg        <= '0;
            slot_reg       <= '0;
            slot_ok_reg    <= 1'b0;
            gen_reg        <= '0;
            d_reg          <= '0;
            ms_reg         <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            out_slot_reg   <= '0;
            out_gen_reg    <= '0;
            dense_reg      <= '0;
            moved_reg      <= 1'b0;
            moved_from_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            live_reg       <= live_next;
            act_reg        <= act_next;
            slot_reg       <= slot_next;
            slot_ok_reg    <= slot_ok_next;
            gen_reg        <= gen_next;
            d_reg          <= d_next;
            ms_reg         <= ms_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            out_slot_reg   <= out_slot_next;
            out_gen_reg    <= out_gen_next;
            dense_reg      <= dense_next;
            moved_reg      <= moved_next;
            moved_from_reg <= moved_from_next;
            count_reg      <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_slot       = out_slot_reg;
    assign out_generation = out_gen_reg;
    assign dense_index    = dense_reg;
    assign moved          = moved_reg;
    assign moved_from     = moved_from_reg;
    assign live_count     = count_reg;

endmodule

### sv/generational_handle_slot_map_top.sv
// Generational slot map: one word per item; update and errors read the slot memory once,
// add and remove chain reads of it and of the dense/free index memory, and remove reads
// further when the last dense entry moves; one item in flight at a time.
// Result is registered; the next word is taken while a result waits on out_stall.
// Reset: asynchronous, active low; then a pass over every slot clears the slot memory
// and loads the index memory, with in_stall high.
module generational_handle_slot_map_top import ghsm_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int GEN_WIDTH = GEN_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ACTION_W-1:0]    action,
    input  logic [IN_SLOT_W-1:0]   slot,
    input  logic [IN_GEN_W-1:0]    generation,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [OUT_SLOT_W-1:0]  out_slot,
    output logic [OUT_GEN_W-1:0]   out_generation,
    output logic [OUT_IDX_W-1:0]   dense_index,
    output logic                   moved,
    output logic [OUT_IDX_W-1:0]   moved_from,
    output logic [OUT_COUNT_W-1:0] live_count
);

    localparam int SW  = $clog2(CAPACITY);
    localparam int A_W = 1 + GEN_WIDTH + SW;

    logic           a_we;
    logic [SW-1:0]  a_waddr;
    logic [A_W-1:0] a_wdata;
    logic           a_re;
    logic [SW-1:0]  a_raddr;
    logic [A_W-1:0] a_rdata;
    logic           b_we;
    logic [SW-1:0]  b_waddr;
    logic [SW-1:0]  b_wdata;
    logic           b_re;
    logic [SW-1:0]  b_raddr;
    logic [SW-1:0]  b_rdata;

    ghsm_ram #(
        .WIDTH (A_W),
        .DEPTH (CAPACITY)
    ) u_slot_mem (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ghsm_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_index_mem (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    ghsm_ctrl #(
        .CAPACITY  (CAPACITY),
        .GEN_WIDTH (GEN_WIDTH),
        .SW        (SW),
        .A_W       (A_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .slot           (slot),
        .generation     (generation),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_slot       (out_slot),
        .out_generation (out_generation),
        .dense_index    (dense_index),
        .moved          (moved),
        .moved_from     (moved_from),
        .live_count     (live_count),
        .a_we           (a_we),
        .a_waddr        (a_waddr),
        .a_wdata        (a_wdata),
        .a_re           (a_re),
        .a_raddr        (a_raddr),
        .a_rdata        (a_rdata),
        .b_we           (b_we),
        .b_waddr        (b_waddr),
        .b_wdata        (b_wdata),
        .b_re           (b_re),
        .b_raddr        (b_raddr),
        .b_rdata        (b_rdata)
    );

endmodule

### bench/tb_generational_handle_slot_map_top.sv
// Testbench for generational_handle_slot_map_top: directed, slot reuse and random traffic.
module tb_generational_handle_slot_map_top;
    import ghsm_pkg::*;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OUT_SLOT_W-1:0]  out_slot;
        logic [OUT_GEN_W-1:0]   out_generation;
        logic [OUT_IDX_W-1:0]   dense_index;
        logic                   moved;
        logic [OUT_IDX_W-1:0]   moved_from;
        logic [OUT_COUNT_W-1:0] live_count;
    } map_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ACTION_W-1:0]    action = '0;
    logic [IN_SLOT_W-1:0]   slot = '0;
    logic [IN_GEN_W-1:0]    generation = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [OUT_SLOT_W-1:0]  out_slot;
    logic [OUT_GEN_W-1:0]   out_generation;
    logic [OUT_IDX_W-1:0]   dense_index;
    logic                   moved;
    logic [OUT_IDX_W-1:0]   moved_from;
    logic [OUT_COUNT_W-1:0] live_count;

    generational_handle_slot_map_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .slot          (slot),
        .generation    (generation),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_slot      (out_slot),
        .out_generation(out_generation),
        .dense_index   (dense_index),
        .moved         (moved),
        .moved_from    (moved_from),
        .live_count    (live_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted slot map state
    int                   free_slots[SLOTS];
    int                   free_count;
    bit                   live_of_slot[SLOTS];
    logic [OUT_GEN_W-1:0] gen_of_slot[SLOTS];
    int                   dense_of_slot[SLOTS];
    int                   slot_of_dense[SLOTS];
    int                   entries;

    map_result_t pending_results[$];
    map_result_t arrived_want;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;

    function automatic void map_clear();
        for (int i = 0; i < SLOTS; i++)
        begin
            free_slots[i]    = SLOTS - 1 - i;
            live_of_slot[i]  = 1'b0;
            gen_of_slot[i]   = '0;
            dense_of_slot[i] = 0;
            slot_of_dense[i] = 0;
        end
        free_count = SLOTS;
        entries    = 0;
    endfunction

    function automatic map_result_t map_apply(input logic [ACTION_W-1:0] act,
                                              input logic [IN_SLOT_W-1:0] sl,
                                              input logic [IN_GEN_W-1:0] gn);
        map_result_t r;
        int idx, d, last, ns, ms;
        bit ok;
        r   = '0;
        idx = int'(sl);
        ok  = idx < SLOTS;
        if (ok)
            ok = live_of_slot[idx] && gen_of_slot[idx] == gn && entries != 0
                 && dense_of_slot[idx] < entries;
        if (act == ACT_ADD)
        begin
            if (free_count == 0 || entries >= SLOTS)
                r.status = ST_FULL;
            else
            begin
                free_count--;
                ns = free_slots[free_count];
                d  = entries;
                live_of_slot[ns]  = 1'b1;
                dense_of_slot[ns] = d;
                slot_of_dense[d]  = ns;
                entries++;
                r.status         = ST_OK;
                r.out_slot       = OUT_SLOT_W'(ns);
                r.out_generation = gen_of_slot[ns];
                r.dense_index    = OUT_IDX_W'(d);
            end
        end
        else if ((act != ACT_UPDATE && act != ACT_REMOVE) || !ok)
            r.status = ST_BAD;
        else if (act == ACT_UPDATE)
        begin
            r.status      = ST_OK;
            r.out_slot    = OUT_SLOT_W'(idx);
            r.dense_index = OUT_IDX_W'(dense_of_slot[idx]);
        end
        else
        begin
            d    = dense_of_slot[idx];
            last = entries - 1;
            if (d != last)
            begin
                ms = slot_of_dense[last];
                slot_of_dense[d]  = ms;
                dense_of_slot[ms] = d;
                r.moved      = 1'b1;
                r.moved_from = OUT_IDX_W'(last);
            end
            entries = last;
            live_of_slot[idx] = 1'b0;
            gen_of_slot[idx]  = gen_of_slot[idx] + 1'b1;
            if (free_count < SLOTS)
            begin
                free_slots[free_count] = idx;
                free_count++;
            end
            r.status      = ST_OK;
            r.out_slot    = OUT_SLOT_W'(idx);
            r.dense_index = OUT_IDX_W'(d);
        end
        r.live_count = OUT_COUNT_W'(entries);
        return r;
    endfunction

    function automatic int pick_live_slot();
        int start;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
            if (live_of_slot[(start + k) % SLOTS])
                return (start + k) % SLOTS;
        return -1;
    endfunction

    // call at a rising edge; returns at the edge where the word was taken
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [IN_SLOT_W-1:0] sl,
                             input logic [IN_GEN_W-1:0] gn, output map_result_t r);
        if (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        slot       <= sl;
        generation <= gn;
        do
            @(posedge clk);
        while (in_stall);
        r = map_apply(act, sl, gn);
        pending_results.insert(pending_results.size(), r);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no prediction pending");
                mismatches++;
            end
            else
            begin
                arrived_want = pending_results.pop_front();
                check_field("status", 32'(arrived_want.status), 32'(status));
                check_field("out_slot", 32'(arrived_want.out_slot), 32'(out_slot));
                check_field("out_generation", 32'(arrived_want.out_generation),
                            32'(out_generation));
                check_field("dense_index", 32'(arrived_want.dense_index), 32'(dense_index));
                check_field("moved", 32'(arrived_want.moved), 32'(moved));
                check_field("moved_from", 32'(arrived_want.moved_from), 32'(moved_from));
                check_field("live_count", 32'(arrived_want.live_count), 32'(live_count));
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 33);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_generational_handle_slot_map_top: FAIL");
            $finish;
        end
    end

    task automatic test_bad_handles();
        map_result_t r;
        send_word(ACT_UPDATE, 8'd0, 16'd0, r);
        send_word(ACT_REMOVE, 8'd63, 16'd0, r);
        send_word(ACT_UPDATE, 8'd64, 16'd0, r);
        send_word(ACT_REMOVE, 8'd255, 16'hFFFF, r);
        send_word(ACT_UNUSED, 8'd0, 16'd0, r);
    endtask

    task automatic test_add_update_remove();
        map_result_t r;
        repeat (4) send_word(ACT_ADD, 8'hFF, 16'hFFFF, r);
        send_word(ACT_UPDATE, 8'd3, 16'd0, r);
        send_word(ACT_UPDATE, 8'd2, 16'hFFFF, r);
        send_word(ACT_REMOVE, 8'd0, 16'd0, r);      // hole at head, last entry moves
        send_word(ACT_REMOVE, 8'd2, 16'd0, r);
        send_word(ACT_REMOVE, 8'd0, 16'd0, r);      // stale after bump
        send_word(ACT_UPDATE, 8'd0, 16'd1, r);      // right generation, slot free
        send_word(ACT_ADD, 8'd0, 16'd0, r);
        send_word(ACT_UNUSED, 8'd1, 16'd0, r);
        send_word(ACT_REMOVE, 8'd1, 16'd0, r);
    endtask

    task automatic test_backpressure();
        map_result_t r;
        int s;
        hold_off = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            s = pick_live_slot();
            if (i % 2 == 0 || s < 0)
                send_word(ACT_ADD, 8'd0, 16'd0, r);
            else
                send_word(ACT_UPDATE, IN_SLOT_W'(s), gen_of_slot[s], r);
        end
    endtask

    task automatic test_slot_reuse();
        map_result_t r;
        calm = 1'b1;
        for (int n = 0; n < 50; n++)
        begin
            send_word(ACT_ADD, 8'd0, 16'd0, r);
            send_word(ACT_REMOVE, IN_SLOT_W'(r.out_slot), r.out_generation, r);
        end
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        map_result_t r;
        int pick, s, add_end;
        bit grow;
        grow = 1'b1;
        for (int i = 0; i < 900; i++)
        begin
            if (i % 160 == 159)
                grow = !grow;
            add_end = grow ? 70 : 30;
            pick = $urandom_range(99);
            s = pick_live_slot();
            if (pick < 7)
                send_word(ACTION_W'($urandom_range(3)), IN_SLOT_W'($urandom_range(255)),
                          IN_GEN_W'($urandom_range(65535)), r);
            else if (pick < 14)
            begin
                s = $urandom_range(SLOTS - 1);
                send_word($urandom_range(1) ? ACT_UPDATE : ACT_REMOVE, IN_SLOT_W'(s),
                          gen_of_slot[s] + IN_GEN_W'($urandom_range(2)) - 16'd1, r);
            end
            else if (pick < add_end || s < 0)
                send_word(ACT_ADD, IN_SLOT_W'($urandom_range(255)),
                          IN_GEN_W'($urandom_range(65535)), r);
            else if (pick < add_end + 15)
                send_word(ACT_UPDATE, IN_SLOT_W'(s), gen_of_slot[s], r);
            else
                send_word(ACT_REMOVE, IN_SLOT_W'(s), gen_of_slot[s], r);
        end
    endtask

    initial
    begin
        map_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_bad_handles();
        test_add_update_remove();
        test_backpressure();
        test_slot_reuse();
        test_random_traffic();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_generational_handle_slot_map_top: PASS");
        else
            $display("tb_generational_handle_slot_map_top: FAIL");
        $finish;
    end

endmodule
